[hw/rtl/gimq_pkg.sv]
// shared constants, types and reduction helpers for the gaussian integer multiplier
`default_nettype none

package gimq_pkg;

	// modulus and derived widths
	localparam int unsigned Q       = 12289;
	localparam int unsigned IN_W    = 16;
	localparam int unsigned RES_W   = 14;
	localparam int unsigned PROD_W  = 28;
	localparam int unsigned SUM_W   = 29;
	localparam int unsigned REM_W   = 15;

	// q*q, used to keep the real-part difference non-negative
	localparam logic [PROD_W-1:0] QSQ = PROD_W'(Q * Q);

	// reciprocal for the quotient estimate: floor(2^32 / q)
	localparam int unsigned RECIP_SHIFT = 32;
	localparam int unsigned RECIP_W     = 19;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(349496);
	localparam int unsigned WIDE_W      = SUM_W + RECIP_W;
	localparam int unsigned QUOT_W      = 15;

	// modulus at the widths it is used at
	localparam logic [RES_W-1:0] Q_RES = RES_W'(Q);
	localparam logic [REM_W-1:0] Q_REM = REM_W'(Q);
	localparam logic [IN_W-1:0]  Q_IN  = IN_W'(Q);

	// per-stage load enables of the pipeline
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} pipe_en_t;

	// final correction: value below 2q to canonical residue
	function automatic logic [RES_W-1:0] cond_sub(input logic [REM_W-1:0] r);
		logic [REM_W-1:0] d;
		d = r - Q_REM;
		cond_sub = (r >= Q_REM) ? d[RES_W-1:0] : r[RES_W-1:0];
	endfunction

	// 16-bit coefficient mod q, quotient taken from the top five bits
	function automatic logic [RES_W-1:0] reduce_in(input logic [IN_W-1:0] x);
		logic [4:0]      top;
		logic [2:0]      k;
		logic [IN_W-1:0] kq;
		logic [IN_W-1:0] r;
		top = x[IN_W-1:IN_W-5];
		if (top <= 5'd6) begin
			k = 3'd0;
		end else if (top <= 5'd12) begin
			k = 3'd1;
		end else if (top <= 5'd18) begin
			k = 3'd2;
		end else if (top <= 5'd24) begin
			k = 3'd3;
		end else if (top <= 5'd30) begin
			k = 3'd4;
		end else begin
			k = 3'd5;
		end
		kq = IN_W'(k) * Q_IN;
		r = x - kq;
		reduce_in = cond_sub(r[REM_W-1:0]);
	endfunction

endpackage

`default_nettype wire

[hw/rtl/gimq_in_reduce.sv]
// stage 1: reduces the four input coefficients modulo q
`default_nettype none

module gimq_in_reduce (
	input  wire logic                          clk,
	input  wire gimq_pkg::pipe_en_t            en,
	input  wire logic [gimq_pkg::IN_W-1:0]     a_real,
	input  wire logic [gimq_pkg::IN_W-1:0]     a_imag,
	input  wire logic [gimq_pkg::IN_W-1:0]     b_real,
	input  wire logic [gimq_pkg::IN_W-1:0]     b_imag,
	output logic      [gimq_pkg::RES_W-1:0]    ar_s1,
	output logic      [gimq_pkg::RES_W-1:0]    ai_s1,
	output logic      [gimq_pkg::RES_W-1:0]    br_s1,
	output logic      [gimq_pkg::RES_W-1:0]    bi_s1
);

	// table quotient, subtract, one correction per lane
	always_ff @(posedge clk) begin
		if (en.s1) begin
			ar_s1 <= gimq_pkg::reduce_in(a_real);
			ai_s1 <= gimq_pkg::reduce_in(a_imag);
			br_s1 <= gimq_pkg::reduce_in(b_real);
			bi_s1 <= gimq_pkg::reduce_in(b_imag);
		end
	end

endmodule

`default_nettype wire

[hw/rtl/gimq_cmul.sv]
// stages 2 and 3: four partial products and their complex combination
`default_nettype none

module gimq_cmul (
	input  wire logic                          clk,
	input  wire gimq_pkg::pipe_en_t            en,
	input  wire logic [gimq_pkg::RES_W-1:0]    ar_s1,
	input  wire logic [gimq_pkg::RES_W-1:0]    ai_s1,
	input  wire logic [gimq_pkg::RES_W-1:0]    br_s1,
	input  wire logic [gimq_pkg::RES_W-1:0]    bi_s1,
	output logic      [gimq_pkg::SUM_W-1:0]    re_sum_s3,
	output logic      [gimq_pkg::SUM_W-1:0]    im_sum_s3
);

	logic [gimq_pkg::PROD_W-1:0] rr_s2;
	logic [gimq_pkg::PROD_W-1:0] ii_s2;
	logic [gimq_pkg::PROD_W-1:0] ri_s2;
	logic [gimq_pkg::PROD_W-1:0] ir_s2;
	logic [gimq_pkg::PROD_W-1:0] neg_ii;

	// partial products, each below q*q
	always_ff @(posedge clk) begin
		if (en.s2) begin
			rr_s2 <= gimq_pkg::PROD_W'(ar_s1) * gimq_pkg::PROD_W'(br_s1);
			ii_s2 <= gimq_pkg::PROD_W'(ai_s1) * gimq_pkg::PROD_W'(bi_s1);
			ri_s2 <= gimq_pkg::PROD_W'(ar_s1) * gimq_pkg::PROD_W'(bi_s1);
			ir_s2 <= gimq_pkg::PROD_W'(ai_s1) * gimq_pkg::PROD_W'(br_s1);
		end
	end

	// real part offset by q*q so it never goes negative
	assign neg_ii = gimq_pkg::QSQ - ii_s2;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			re_sum_s3 <= gimq_pkg::SUM_W'(rr_s2) + gimq_pkg::SUM_W'(neg_ii);
			im_sum_s3 <= gimq_pkg::SUM_W'(ri_s2) + gimq_pkg::SUM_W'(ir_s2);
		end
	end

endmodule

`default_nettype wire

[hw/rtl/gimq_reduce.sv]
// stages 4 to 6: reciprocal-based reduction of a value below 2*q*q
`default_nettype none

module gimq_reduce (
	input  wire logic                          clk,
	input  wire gimq_pkg::pipe_en_t            en,
	input  wire logic [gimq_pkg::SUM_W-1:0]    sum_s3,
	output logic      [gimq_pkg::RES_W-1:0]    res_s6
);

	logic [gimq_pkg::WIDE_W-1:0] est_s4;
	logic [gimq_pkg::SUM_W-1:0]  sum_s4;
	logic [gimq_pkg::QUOT_W-1:0] quot;
	logic [gimq_pkg::SUM_W-1:0]  quot_q_prod;
	logic [gimq_pkg::REM_W-1:0]  rem_s5;

	// quotient estimate, at most one below the true quotient
	always_ff @(posedge clk) begin
		if (en.s4) begin
			est_s4 <= gimq_pkg::WIDE_W'(sum_s3) * gimq_pkg::WIDE_W'(gimq_pkg::RECIP);
			sum_s4 <= sum_s3;
		end
	end

	assign quot        = est_s4[gimq_pkg::RECIP_SHIFT +: gimq_pkg::QUOT_W];
	assign quot_q_prod = gimq_pkg::SUM_W'(quot) * gimq_pkg::SUM_W'(gimq_pkg::Q);

	// remainder lands below 2q, so the low bits are enough
	always_ff @(posedge clk) begin
		if (en.s5) begin
			rem_s5 <= sum_s4[gimq_pkg::REM_W-1:0] - quot_q_prod[gimq_pkg::REM_W-1:0];
		end
	end

	// final correction to the canonical residue
	always_ff @(posedge clk) begin
		if (en.s6) begin
			res_s6 <= gimq_pkg::cond_sub(rem_s5);
		end
	end

endmodule

`default_nettype wire

[hw/rtl/gaussian_int_mul_mod_q.sv]
// gaussian integer product modulo 12289, six-stage pipeline
// each word passes the stage registers s1 to s6 in turn before it shows at the outputs
// throughput: one word per cycle unless the output stalls; each stage register holds one word
// a stall at the output backs up stage by stage, so bubbles in the pipe still take words
// reset (arst_n low, asynchronous) clears all stage valid bits; data registers are not reset
`default_nettype none

module gaussian_int_mul_mod_q (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [gimq_pkg::IN_W-1:0]     a_real,
	input  wire logic [gimq_pkg::IN_W-1:0]     a_imag,
	input  wire logic [gimq_pkg::IN_W-1:0]     b_real,
	input  wire logic [gimq_pkg::IN_W-1:0]     b_imag,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [gimq_pkg::RES_W-1:0]    prod_real,
	output logic      [gimq_pkg::RES_W-1:0]    prod_imag
);

	gimq_pkg::pipe_en_t en;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	logic [gimq_pkg::RES_W-1:0] ar_s1, ai_s1, br_s1, bi_s1;
	logic [gimq_pkg::SUM_W-1:0] re_sum_s3, im_sum_s3;

	// a stage loads when it is empty or its word moves on
	always_comb begin
		en.s6 = !vld_s6 || out_ready;
		en.s5 = !vld_s5 || en.s6;
		en.s4 = !vld_s4 || en.s5;
		en.s3 = !vld_s3 || en.s4;
		en.s2 = !vld_s2 || en.s3;
		en.s1 = !vld_s1 || en.s2;
	end

	assign in_ready  = en.s1;
	assign out_valid = vld_s6;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en.s1) vld_s1 <= in_valid;
			if (en.s2) vld_s2 <= vld_s1;
			if (en.s3) vld_s3 <= vld_s2;
			if (en.s4) vld_s4 <= vld_s3;
			if (en.s5) vld_s5 <= vld_s4;
			if (en.s6) vld_s6 <= vld_s5;
		end
	end

	// input reduction
	gimq_in_reduce u_in_reduce (
		.clk    (clk),
		.en     (en),
		.a_real (a_real),
		.a_imag (a_imag),
		.b_real (b_real),
		.b_imag (b_imag),
		.ar_s1  (ar_s1),
		.ai_s1  (ai_s1),
		.br_s1  (br_s1),
		.bi_s1  (bi_s1)
	);

	// complex multiply
	gimq_cmul u_cmul (
		.clk       (clk),
		.en        (en),
		.ar_s1     (ar_s1),
		.ai_s1     (ai_s1),
		.br_s1     (br_s1),
		.bi_s1     (bi_s1),
		.re_sum_s3 (re_sum_s3),
		.im_sum_s3 (im_sum_s3)
	);

	// output reduction, one unit per part
	gimq_reduce u_reduce_re (
		.clk    (clk),
		.en     (en),
		.sum_s3 (re_sum_s3),
		.res_s6 (prod_real)
	);

	gimq_reduce u_reduce_im (
		.clk    (clk),
		.en     (en),
		.sum_s3 (im_sum_s3),
		.res_s6 (prod_imag)
	);

endmodule

`default_nettype wire

[hw/rtl/gimq_checker.sv]
// port-level assertions for the gaussian integer multiplier, bound to the top level
`default_nettype none

module gimq_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_ready,
	input  wire logic                          out_valid,
	input  wire logic                          out_ready,
	input  wire logic [gimq_pkg::RES_W-1:0]    prod_real,
	input  wire logic [gimq_pkg::RES_W-1:0]    prod_imag
);

	// no result word while reset is held
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result word valid during reset");

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(prod_real) && $stable(prod_imag))
		else $error("stalled result word changed");

	// results are canonical residues
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (prod_real < gimq_pkg::Q_RES) && (prod_imag < gimq_pkg::Q_RES))
		else $error("result word not fully reduced");

	// pipeline only refuses words when the output is stalled
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input refused while output drains");

endmodule

bind gaussian_int_mul_mod_q gimq_checker u_gimq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.prod_real (prod_real),
	.prod_imag (prod_imag)
);

`default_nettype wire
